[hdl/spcg_pkg.sv]
// Shared types and constants for the scan point cluster gate.
// No dependencies; imported by spcg_div and scan_point_cluster_gate.
`default_nettype none

package spcg_pkg;

	// Saturating coordinate sum width and centroid width
	localparam int SUM_W  = 42;
	localparam int MEAN_W = 32;
	localparam int CELL_W = 16;
	localparam int EXT_W  = 6;
	localparam int LBL_W  = 16;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_GAP_CELLS      = 2'd0;
	localparam logic [1:0] REG_MIN_RANGE      = 2'd1;
	localparam logic [1:0] REG_MAX_RANGE_EXCL = 2'd2;
	localparam logic [1:0] REG_MAX_AREA_EXCL  = 2'd3;

	localparam logic [3:0]  GAP_CELLS_RST      = 4'd4;
	localparam logic [5:0]  MIN_RANGE_RST      = 6'd2;
	localparam logic [5:0]  MAX_RANGE_EXCL_RST = 6'd17;
	localparam logic [11:0] MAX_AREA_EXCL_RST  = 12'd60;

	localparam logic [LBL_W-1:0] LABEL_FIRST = 16'd1;
	localparam logic [LBL_W-1:0] LABEL_SAT   = 16'hFFFF;

	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [MEAN_W-1:0] mean_t;

	typedef struct packed {
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               scan_end;
	} in_word_t;

	typedef struct packed {
		logic [15:0]        cluster_label;
		logic [5:0]         extent_x;
		logic [5:0]         extent_y;
		logic signed [31:0] centroid_x;
		logic signed [31:0] centroid_y;
		logic signed [31:0] centroid_z;
		logic               last_of_scan;
	} out_word_t;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

[hdl/scan_point_cluster_gate.sv]
// Scan point cluster gate: breakpoint clustering of laser scan points.
// Depends on spcg_pkg and spcg_div.
//
// Points arrive one word at a time in scan order. A point joins the open
// cluster while both of its cell label deltas to the previous point stay,
// in magnitude, below gap_cells and the cluster holds fewer than
// MAX_CLUSTER_POINTS points; otherwise the open cluster closes and the point
// opens a new one. A closed cluster yields one output word (label, cell
// extents, centroid truncated toward zero) only if both extents lie in
// [min_range, max_range_excl) and their product is below max_area_excl.
// A point flagged scan_end closes its own cluster too, so one input word may
// give up to two output words; last_of_scan marks the final one actually
// emitted, and the label count restarts at 1. Coordinate sums saturate at
// 42 bits. A cluster that the gate drops skips the divider; one that passes
// goes through the shared three-lane divider, one quotient bit a cycle, and
// then waits for the output register to free before its word is handed over.
// The input is not ready while a word is in work; a finished output word
// waits in its own register, so the next point is taken while it is still
// unread. Registers sit on an APB port at byte offsets 0, 4, 8 and 12 and
// should be written only while idle.
`default_nettype none

module scan_point_cluster_gate #(
	parameter int MAX_CLUSTER_POINTS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Point words
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire spcg_pkg::in_word_t            in_word,
	// Cluster words
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output spcg_pkg::out_word_t                out_word,
	// Configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [spcg_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [spcg_pkg::DATA_W-1:0]   pwdata,
	output logic [spcg_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import spcg_pkg::*;

	// Count must be able to hold the cluster limit itself
	localparam int CNT_W = $clog2(MAX_CLUSTER_POINTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CLUSTER_POINTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_JOIN,
		ST_CHECK,
		ST_DIV,
		ST_PUT,
		ST_NEXT
	} state_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [3:0]  gap_cells_q;
	logic [5:0]  min_range_q;
	logic [5:0]  max_range_q;
	logic [11:0] max_area_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_cells_q <= GAP_CELLS_RST;
			min_range_q <= MIN_RANGE_RST;
			max_range_q <= MAX_RANGE_EXCL_RST;
			max_area_q  <= MAX_AREA_EXCL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GAP_CELLS:      gap_cells_q <= pwdata[3:0];
				REG_MIN_RANGE:      min_range_q <= pwdata[5:0];
				REG_MAX_RANGE_EXCL: max_range_q <= pwdata[5:0];
				REG_MAX_AREA_EXCL:  max_area_q  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAP_CELLS:      prdata = DATA_W'(gap_cells_q);
			REG_MIN_RANGE:      prdata = DATA_W'(min_range_q);
			REG_MAX_RANGE_EXCL: prdata = DATA_W'(max_range_q);
			REG_MAX_AREA_EXCL:  prdata = DATA_W'(max_area_q);
			default:            prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer and open-cluster state
	// ------------------------------------------------------------------
	state_t            state_q;
	in_word_t          pt_q;          // point in work
	logic              end_phase_q;   // checking the end-of-scan cluster
	logic              last_flag_q;   // last_of_scan for the word being built
	logic              open_q;
	logic [CELL_W-1:0] prev_x_q;
	logic [CELL_W-1:0] prev_y_q;
	logic [CNT_W-1:0]  count_q;
	logic signed [CELL_W-1:0] min_x_q;
	logic signed [CELL_W-1:0] max_x_q;
	logic signed [CELL_W-1:0] min_y_q;
	logic signed [CELL_W-1:0] max_y_q;
	sum_t              sum_x_q;
	sum_t              sum_y_q;
	sum_t              sum_z_q;
	logic [LBL_W-1:0]  label_q;
	logic [EXT_W-1:0]  ext_x_q;
	logic [EXT_W-1:0]  ext_y_q;
	logic              out_valid_q;
	out_word_t         out_q;

	// Saturating add of a 32-bit coordinate into a 42-bit sum
	function automatic sum_t sat_add(sum_t s, logic signed [31:0] v);
		logic signed [SUM_W:0] r;
		r = {s[SUM_W-1], s} + (SUM_W+1)'(v);
		if (r[SUM_W] != r[SUM_W-1])
			return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			return r[SUM_W-1:0];
	endfunction

	// Join test against the previous point
	logic signed [CELL_W:0] dx, dy;
	logic [CELL_W:0]        adx, ady;
	logic                   join_ok;

	always_comb begin
		dx  = {pt_q.cell_x[CELL_W-1], pt_q.cell_x} - {prev_x_q[CELL_W-1], prev_x_q};
		dy  = {pt_q.cell_y[CELL_W-1], pt_q.cell_y} - {prev_y_q[CELL_W-1], prev_y_q};
		adx = dx[CELL_W] ? (CELL_W+1)'(-dx) : (CELL_W+1)'(dx);
		ady = dy[CELL_W] ? (CELL_W+1)'(-dy) : (CELL_W+1)'(dy);
		join_ok = open_q && (adx < (CELL_W+1)'(gap_cells_q))
		          && (ady < (CELL_W+1)'(gap_cells_q)) && (count_q < CNT_MAX);
	end

	// Acceptance gate on the open cluster's extents
	logic [CELL_W:0]  ext_x, ext_y;
	logic [11:0]      area;
	logic             range_x_ok, range_y_ok, gate_ok, single_ok;

	always_comb begin
		ext_x = ({max_x_q[CELL_W-1], max_x_q} - {min_x_q[CELL_W-1], min_x_q}) + 1'b1;
		ext_y = ({max_y_q[CELL_W-1], max_y_q} - {min_y_q[CELL_W-1], min_y_q}) + 1'b1;
		range_x_ok = (ext_x >= (CELL_W+1)'(min_range_q)) && (ext_x < (CELL_W+1)'(max_range_q));
		range_y_ok = (ext_y >= (CELL_W+1)'(min_range_q)) && (ext_y < (CELL_W+1)'(max_range_q));
		area       = ext_x[EXT_W-1:0] * ext_y[EXT_W-1:0];
		gate_ok    = range_x_ok && range_y_ok && (area < max_area_q);
		// A freshly opened cluster of one point is 1 by 1 cells
		single_ok  = (min_range_q <= 6'd1) && (max_range_q > 6'd1) && (max_area_q > 12'd1);
	end

	// Shared divider for the three centroids
	div_stat_t div_stat;
	mean_t     mean_x, mean_y, mean_z;
	logic      div_start;

	assign div_start = (state_q == ST_CHECK) && gate_ok;

	spcg_div #(
		.CNT_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.sum_x  (sum_x_q),
		.sum_y  (sum_y_q),
		.sum_z  (sum_z_q),
		.count  (count_q),
		.stat   (div_stat),
		.mean_x (mean_x),
		.mean_y (mean_y),
		.mean_z (mean_z)
	);

	logic put_ok;
	assign put_ok   = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pt_q        <= '0;
			end_phase_q <= 1'b0;
			last_flag_q <= 1'b0;
			open_q      <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			count_q     <= '0;
			min_x_q     <= '0;
			max_x_q     <= '0;
			min_y_q     <= '0;
			max_y_q     <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			sum_z_q     <= '0;
			label_q     <= LABEL_FIRST;
			ext_x_q     <= '0;
			ext_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Present a finished word, or drop the flag once the word is taken
			if (state_q == ST_PUT && put_ok)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pt_q    <= in_word;
						state_q <= ST_JOIN;
					end
				end

				ST_JOIN: begin
					prev_x_q <= pt_q.cell_x;
					prev_y_q <= pt_q.cell_y;
					if (join_ok) begin
						// Grow the open cluster
						count_q <= count_q + 1'b1;
						if (pt_q.cell_x < min_x_q) min_x_q <= pt_q.cell_x;
						if (pt_q.cell_x > max_x_q) max_x_q <= pt_q.cell_x;
						if (pt_q.cell_y < min_y_q) min_y_q <= pt_q.cell_y;
						if (pt_q.cell_y > max_y_q) max_y_q <= pt_q.cell_y;
						sum_x_q <= sat_add(sum_x_q, pt_q.point_x);
						sum_y_q <= sat_add(sum_y_q, pt_q.point_y);
						sum_z_q <= sat_add(sum_z_q, pt_q.point_z);
					end else if (!open_q) begin
						// Open a fresh cluster on this point
						open_q  <= 1'b1;
						count_q <= CNT_W'(1);
						min_x_q <= pt_q.cell_x;
						max_x_q <= pt_q.cell_x;
						min_y_q <= pt_q.cell_y;
						max_y_q <= pt_q.cell_y;
						sum_x_q <= SUM_W'(pt_q.point_x);
						sum_y_q <= SUM_W'(pt_q.point_y);
						sum_z_q <= SUM_W'(pt_q.point_z);
					end

					if (!join_ok && open_q) begin
						// Close the old cluster first; it is the last word only if
						// the single-point end cluster behind it will be dropped
						end_phase_q <= 1'b0;
						last_flag_q <= pt_q.scan_end && !single_ok;
						state_q     <= ST_CHECK;
					end else if (pt_q.scan_end) begin
						end_phase_q <= 1'b1;
						last_flag_q <= 1'b1;
						state_q     <= ST_CHECK;
					end else begin
						state_q <= ST_IDLE;
					end
				end

				ST_CHECK: begin
					ext_x_q <= ext_x[EXT_W-1:0];
					ext_y_q <= ext_y[EXT_W-1:0];
					state_q <= gate_ok ? ST_DIV : ST_NEXT;
				end

				ST_DIV: begin
					if (div_stat.done)
						state_q <= ST_PUT;
				end

				ST_PUT: begin
					// Hold until the output register is free
					if (put_ok)
						state_q <= ST_NEXT;
				end

				ST_NEXT: begin
					if (end_phase_q) begin
						// Scan over: drop the cluster, restart the label count
						open_q  <= 1'b0;
						label_q <= LABEL_FIRST;
						state_q <= ST_IDLE;
					end else begin
						if (label_q != LABEL_SAT)
							label_q <= label_q + 1'b1;
						count_q <= CNT_W'(1);
						min_x_q <= pt_q.cell_x;
						max_x_q <= pt_q.cell_x;
						min_y_q <= pt_q.cell_y;
						max_y_q <= pt_q.cell_y;
						sum_x_q <= SUM_W'(pt_q.point_x);
						sum_y_q <= SUM_W'(pt_q.point_y);
						sum_z_q <= SUM_W'(pt_q.point_z);
						if (pt_q.scan_end) begin
							end_phase_q <= 1'b1;
							last_flag_q <= 1'b1;
							state_q     <= ST_CHECK;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output word; load only as the register is handed a new word
	always_ff @(posedge clk) begin
		if (state_q == ST_PUT && put_ok) begin
			out_q.cluster_label <= label_q;
			out_q.extent_x      <= ext_x_q;
			out_q.extent_y      <= ext_y_q;
			out_q.centroid_x    <= mean_x;
			out_q.centroid_y    <= mean_y;
			out_q.centroid_z    <= mean_z;
			out_q.last_of_scan  <= last_flag_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("divider busy while taking a new point");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the wait state");

	a_count_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (count_q != '0 && count_q <= CNT_MAX))
		else $error("open cluster point count out of bounds");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		(min_x_q <= max_x_q) && (min_y_q <= max_y_q))
		else $error("cluster cell bounds crossed");

	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT && put_ok) |=> out_valid_q)
		else $error("finished cluster word not presented");

	a_label_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		label_q != '0)
		else $error("cluster label reached zero");

endmodule

`default_nettype wire

[hdl/spcg_div.sv]
// Three-lane restoring divider: signed sums over an unsigned point count.
// One quotient bit per lane per cycle; depends on spcg_pkg.
`default_nettype none

module spcg_div #(
	parameter int CNT_W = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire spcg_pkg::sum_t    sum_x,
	input  wire spcg_pkg::sum_t    sum_y,
	input  wire spcg_pkg::sum_t    sum_z,
	input  wire logic [CNT_W-1:0]  count,
	output spcg_pkg::div_stat_t    stat,
	output spcg_pkg::mean_t        mean_x,
	output spcg_pkg::mean_t        mean_y,
	output spcg_pkg::mean_t        mean_z
);
	import spcg_pkg::*;

	localparam int LANES = 3;
	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0] acc_q [LANES];
	logic [CNT_W-1:0] rem_q [LANES];
	logic             neg_q [LANES];
	logic [CNT_W-1:0] den_q;
	logic [STEP_W-1:0] step_q;
	logic             busy_q;
	logic             done_q;

	sum_t             sum_in [LANES];
	logic [SUM_W-1:0] mag_in [LANES];
	logic [CNT_W:0]   trial  [LANES];
	logic [CNT_W:0]   diff   [LANES];
	logic             take   [LANES];
	mean_t            mean_o [LANES];

	assign sum_in[0] = sum_x;
	assign sum_in[1] = sum_y;
	assign sum_in[2] = sum_z;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag_in[i] = sum_in[i][SUM_W-1] ? SUM_W'(-sum_in[i]) : SUM_W'(sum_in[i]);
			trial[i]  = {rem_q[i], acc_q[i][SUM_W-1]};
			diff[i]   = trial[i] - {1'b0, den_q};
			take[i]   = trial[i] >= {1'b0, den_q};
			mean_o[i] = neg_q[i] ? MEAN_W'(-acc_q[i][MEAN_W-1:0])
			                     : MEAN_W'(acc_q[i][MEAN_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits into the dividend register as it drains
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= count;
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= mag_in[i];
				rem_q[i] <= '0;
				neg_q[i] <= sum_in[i][SUM_W-1];
			end
		end else if (busy_q) begin
			for (int i = 0; i < LANES; i++) begin
				acc_q[i] <= {acc_q[i][SUM_W-2:0], take[i]};
				rem_q[i] <= take[i] ? diff[i][CNT_W-1:0] : trial[i][CNT_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign mean_x    = mean_o[0];
	assign mean_y    = mean_o[1];
	assign mean_z    = mean_o[2];

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for scan_point_cluster_gate: point words in, cluster words out.
// Depends on spcg_pkg and the cluster gate RTL. It carries its own clustering predictor,
// so the expected cluster words are worked out here.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spcg_pkg::*;

	localparam int MAX_PTS       = 1024;
	localparam int SETTLE_CYCLES = 120;       // above the worst cost of a single word
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int PRINT_CAP     = 40;

	localparam longint SUM_TOP    = 64'sh0000_01FF_FFFF_FFFF;
	localparam longint SUM_BOTTOM = -SUM_TOP - 1;

	localparam logic signed [31:0] COORD_MIN = 32'h8000_0000;
	localparam logic signed [31:0] COORD_MAX = 32'h7FFF_FFFF;

	// Clock, reset and every block input start from known values
	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            in_valid = 1'b0;
	in_word_t        in_word  = '0;
	logic            out_ready = 1'b0;
	logic            psel     = 1'b0;
	logic            penable  = 1'b0;
	logic            pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr  = '0;
	logic [DATA_W-1:0] pwdata = '0;

	logic            in_ready;
	logic            out_valid;
	out_word_t       out_word;
	logic [DATA_W-1:0] prdata;
	logic            pready;

	scan_point_cluster_gate #(
		.MAX_CLUSTER_POINTS(MAX_PTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register mirror used by the predictor
	int cfg_gap;
	int cfg_min;
	int cfg_max;
	int cfg_area;

	// Open cluster as the predictor sees it
	bit     clu_open;
	int     prev_cx;
	int     prev_cy;
	int     clu_pts;
	int     lo_cx;
	int     hi_cx;
	int     lo_cy;
	int     hi_cy;
	longint acc_x;
	longint acc_y;
	longint acc_z;
	int     clu_label;

	// Cluster words still owed by the block, oldest first
	out_word_t due_clusters[$];
	out_word_t want_word;

	int errors        = 0;
	int items_sent    = 0;
	int clusters_seen = 0;
	int cycle_count   = 0;
	bit idle_on       = 1'b0;
	int long_hold     = 0;

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		if (errors < PRINT_CAP)
			$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		errors++;
	endtask

	// ---------------------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------------------

	function automatic void reset_model();
		cfg_gap   = int'(GAP_CELLS_RST);
		cfg_min   = int'(MIN_RANGE_RST);
		cfg_max   = int'(MAX_RANGE_EXCL_RST);
		cfg_area  = int'(MAX_AREA_EXCL_RST);
		clu_open  = 1'b0;
		prev_cx   = 0;
		prev_cy   = 0;
		clu_pts   = 0;
		lo_cx     = 0;
		hi_cx     = 0;
		lo_cy     = 0;
		hi_cy     = 0;
		acc_x     = 0;
		acc_y     = 0;
		acc_z     = 0;
		clu_label = int'(LABEL_FIRST);
	endfunction

	function automatic longint add_sat(input longint s, input longint v);
		longint r;
		r = s + v;
		if (r > SUM_TOP)
			return SUM_TOP;
		if (r < SUM_BOTTOM)
			return SUM_BOTTOM;
		return r;
	endfunction

	// Mean truncated toward zero, kept to the low 32 bits
	function automatic logic [31:0] mean_trunc(input longint s, input int n);
		longint unsigned mag;
		longint unsigned q;
		mag = (s < 0) ? longint'(-s) : s;
		q   = mag / longint'((n == 0) ? 1 : n);
		if (s < 0)
			q = -q;
		return q[31:0];
	endfunction

	// Gate the open cluster against the acceptance window; 1 when it yields a word
	function automatic bit gate_cluster(output out_word_t r);
		int ex;
		int ey;
		ex = hi_cx - lo_cx + 1;
		ey = hi_cy - lo_cy + 1;
		r  = '0;
		if (ex < cfg_min || ex >= cfg_max || ey < cfg_min || ey >= cfg_max)
			return 1'b0;
		if (longint'(ex) * longint'(ey) >= longint'(cfg_area))
			return 1'b0;
		r.cluster_label = 16'(clu_label);
		r.extent_x      = 6'(ex);
		r.extent_y      = 6'(ey);
		r.centroid_x    = mean_trunc(acc_x, clu_pts);
		r.centroid_y    = mean_trunc(acc_y, clu_pts);
		r.centroid_z    = mean_trunc(acc_z, clu_pts);
		return 1'b1;
	endfunction

	// Fold one accepted point into the cluster state and queue the words it causes
	function automatic void fold_point(input in_word_t w);
		out_word_t made [2];
		out_word_t r;
		int        n;
		int        cx;
		int        cy;
		int        dx;
		int        dy;
		bit        joins;
		n  = 0;
		cx = w.cell_x;
		cy = w.cell_y;
		dx = cx - prev_cx;
		dy = cy - prev_cy;
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		joins = clu_open && dx < cfg_gap && dy < cfg_gap && clu_pts < MAX_PTS;
		if (joins) begin
			clu_pts++;
			if (cx < lo_cx) lo_cx = cx;
			if (cx > hi_cx) hi_cx = cx;
			if (cy < lo_cy) lo_cy = cy;
			if (cy > hi_cy) hi_cy = cy;
			acc_x = add_sat(acc_x, w.point_x);
			acc_y = add_sat(acc_y, w.point_y);
			acc_z = add_sat(acc_z, w.point_z);
		end else begin
			if (clu_open) begin
				if (gate_cluster(r)) begin
					made[n] = r;
					n++;
				end
				if (clu_label < int'(LABEL_SAT))
					clu_label++;
			end
			clu_open = 1'b1;
			clu_pts  = 1;
			lo_cx    = cx;
			hi_cx    = cx;
			lo_cy    = cy;
			hi_cy    = cy;
			acc_x    = w.point_x;
			acc_y    = w.point_y;
			acc_z    = w.point_z;
		end
		prev_cx = cx;
		prev_cy = cy;
		if (w.scan_end) begin
			if (gate_cluster(r)) begin
				made[n] = r;
				n++;
			end
			if (n > 0)
				made[n-1].last_of_scan = 1'b1;
			clu_open  = 1'b0;
			clu_label = int'(LABEL_FIRST);
		end
		for (int i = 0; i < n; i++)
			due_clusters = {due_clusters, made[i]};
	endfunction

	// ---------------------------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------------------------

	function automatic in_word_t make_point(input int cx, input int cy, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz, input bit last);
		in_word_t w;
		w.cell_x   = 16'(cx);
		w.cell_y   = 16'(cy);
		w.point_x  = px;
		w.point_y  = py;
		w.point_z  = pz;
		w.scan_end = last;
		return w;
	endfunction

	// Offer one point word; hold valid and payload until the block takes it.
	// Valid is left high after acceptance so back-to-back words need no second
	// assignment in the same step; quiesce drops it.
	task automatic offer_point(input in_word_t w);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_word  <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fold_point(w);
		items_sent++;
	endtask

	// Drop valid, wait for every owed cluster word, then let any word still in work finish
	task automatic quiesce();
		in_valid <= 1'b0;
		while (due_clusters.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register (setup then access), then read it back
	task automatic write_reg(input logic [1:0] idx, input int unsigned value);
		logic [31:0] mask;
		case (idx)
			REG_GAP_CELLS: begin
				mask    = 32'h0000_000F;
				cfg_gap = int'(value & mask);
			end
			REG_MIN_RANGE: begin
				mask    = 32'h0000_003F;
				cfg_min = int'(value & mask);
			end
			REG_MAX_RANGE_EXCL: begin
				mask    = 32'h0000_003F;
				cfg_max = int'(value & mask);
			end
			default: begin
				mask     = 32'h0000_0FFF;
				cfg_area = int'(value & mask);
			end
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if ((prdata & mask) != (value & mask))
			flag_mismatch("register readback", prdata & mask, value & mask);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_window(input int unsigned gap, input int unsigned lo, input int unsigned hi,
			input int unsigned area);
		write_reg(REG_GAP_CELLS, gap);
		write_reg(REG_MIN_RANGE, lo);
		write_reg(REG_MAX_RANGE_EXCL, hi);
		write_reg(REG_MAX_AREA_EXCL, area);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0:       return COORD_MIN;
			1:       return COORD_MAX;
			2, 3:    return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom();
		endcase
	endfunction

	// ---------------------------------------------------------------------------------------
	// Receiver and checker
	// ---------------------------------------------------------------------------------------

	// Sink: random stall bursts while idling is on; a long hold when a test asks for one
	initial begin : result_sink
		int n;
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Compare each accepted cluster word with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			clusters_seen++;
			if (due_clusters.size() == 0) begin
				flag_mismatch("cluster word with none owed", out_word.cluster_label, 0);
			end else begin
				want_word = due_clusters.pop_front();
				if (out_word.cluster_label != want_word.cluster_label)
					flag_mismatch("cluster_label", out_word.cluster_label,
						want_word.cluster_label);
				if (out_word.extent_x != want_word.extent_x)
					flag_mismatch("extent_x", out_word.extent_x, want_word.extent_x);
				if (out_word.extent_y != want_word.extent_y)
					flag_mismatch("extent_y", out_word.extent_y, want_word.extent_y);
				if (out_word.centroid_x != want_word.centroid_x)
					flag_mismatch("centroid_x", out_word.centroid_x, want_word.centroid_x);
				if (out_word.centroid_y != want_word.centroid_y)
					flag_mismatch("centroid_y", out_word.centroid_y, want_word.centroid_y);
				if (out_word.centroid_z != want_word.centroid_z)
					flag_mismatch("centroid_z", out_word.centroid_z, want_word.centroid_z);
				if (out_word.last_of_scan != want_word.last_of_scan)
					flag_mismatch("last_of_scan", out_word.last_of_scan,
						want_word.last_of_scan);
			end
		end
	end

	// Watchdog: bail out well beyond the slowest correct run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------------

	// Reset register values: joins, gap breaks, coordinate extremes, extreme cell labels,
	// the flag landing on an earlier word when the final cluster is rejected, and
	// rejection on area and on extent.
	task automatic test_default_registers();
		offer_point(make_point(0, 0, COORD_MAX, COORD_MIN, 0, 0));
		offer_point(make_point(3, -3, COORD_MAX, COORD_MIN, -3, 0));
		offer_point(make_point(7, -3, 0, 0, 5, 0));
		offer_point(make_point(8, -2, -1, 1, -2, 1));
		// Cell labels at both ends of their range; the last jump spans the whole range
		offer_point(make_point(-32768, 32767, COORD_MIN, COORD_MAX, COORD_MIN, 0));
		offer_point(make_point(-32767, 32766, COORD_MAX, COORD_MIN, COORD_MAX, 0));
		offer_point(make_point(32767, -32768, 0, 0, 0, 1));
		// 8 x 8 overshoots the area bound
		offer_point(make_point(0, 0, 100, 200, 300, 0));
		offer_point(make_point(3, 3, -100, -200, -300, 0));
		offer_point(make_point(6, 6, 7, 8, 9, 0));
		offer_point(make_point(7, 7, 1, 1, 1, 0));
		// Width of 17 hits the exclusive extent bound
		offer_point(make_point(40, 0, 1, 2, 3, 0));
		offer_point(make_point(43, 0, 1, 2, 3, 0));
		offer_point(make_point(46, 1, 1, 2, 3, 0));
		offer_point(make_point(49, 1, 1, 2, 3, 0));
		offer_point(make_point(52, 0, 1, 2, 3, 0));
		offer_point(make_point(55, 1, 1, 2, 3, 0));
		offer_point(make_point(56, 1, 1, 2, 3, 0));
		// Lone point ending the scan: nothing passes, so nothing is flagged
		offer_point(make_point(100, 100, 0, 0, 0, 1));
		quiesce();
	endtask

	// Register extremes: zero gap, two words from one point, empty windows
	task automatic test_register_extremes();
		write_reg(REG_GAP_CELLS, 0);
		offer_point(make_point(5, 5, 10, 20, 30, 0));
		offer_point(make_point(5, 5, 10, 20, 30, 0));
		offer_point(make_point(5, 5, 10, 20, 30, 1));
		quiesce();
		write_reg(REG_MIN_RANGE, 1);
		write_reg(REG_MAX_RANGE_EXCL, 63);
		write_reg(REG_MAX_AREA_EXCL, 4095);
		offer_point(make_point(5, 5, -7, 7, -9, 0));
		offer_point(make_point(5, 5, 11, -13, 15, 1));
		quiesce();
		// Minimum equal to the exclusive maximum leaves no extent acceptable
		set_window(15, 63, 63, 4095);
		offer_point(make_point(0, 0, 1, 1, 1, 0));
		offer_point(make_point(14, -14, 1, 1, 1, 0));
		offer_point(make_point(14, -14, 1, 1, 1, 1));
		quiesce();
		write_reg(REG_MIN_RANGE, 1);
		write_reg(REG_MAX_RANGE_EXCL, 1);
		offer_point(make_point(1, 1, 2, 2, 2, 0));
		offer_point(make_point(2, 2, 2, 2, 2, 1));
		quiesce();
		write_reg(REG_MAX_RANGE_EXCL, 63);
		write_reg(REG_MAX_AREA_EXCL, 1);
		offer_point(make_point(1, 1, 2, 2, 2, 0));
		offer_point(make_point(2, 2, 2, 2, 2, 1));
		quiesce();
	endtask

	// Fill a cluster to the point limit; the next point must open a fresh one.
	// All x at the negative extreme lands the sum exactly on its floor.
	task automatic test_full_cluster();
		int k;
		int zig;
		set_window(4, 1, 63, 4095);
		for (k = 0; k <= MAX_PTS + 1; k++) begin
			zig = k % 14;
			if (zig >= 7)
				zig = 14 - zig;
			offer_point(make_point(zig, -5, COORD_MIN, COORD_MAX, $urandom(), k == MAX_PTS + 1));
		end
		quiesce();
	endtask

	// Hold the sink off for a long stretch while words keep coming, then pause the
	// sender until everything owed has arrived
	task automatic test_output_backpressure();
		int k;
		set_window(4, 1, 63, 4095);
		long_hold = 600;
		for (k = 0; k < 15; k++) begin
			offer_point(make_point(k * 10, k * 10, $urandom(), $urandom(), $urandom(), 0));
			offer_point(make_point(k * 10 + 1, k * 10 - 1, rand_coord(), rand_coord(),
				rand_coord(), k == 14));
		end
		quiesce();
		for (k = 0; k < 6; k++)
			offer_point(make_point(k * 2, 0, rand_coord(), rand_coord(), rand_coord(), k == 5));
		quiesce();
	endtask

	// One scan: mostly a walk that stays inside the gap, with boundary steps,
	// jumps, stray labels and the odd early end of scan
	task automatic random_scan();
		in_word_t w;
		int len;
		int g;
		int cx;
		int cy;
		int k;
		int mode;
		len = $urandom_range(1, 12);
		g   = (cfg_gap == 0) ? 1 : cfg_gap;
		cx  = int'($urandom_range(0, 65535)) - 32768;
		cy  = int'($urandom_range(0, 65535)) - 32768;
		for (k = 0; k < len; k++) begin
			mode = $urandom_range(0, 99);
			if (mode < 70) begin
				cx = cx + int'($urandom_range(0, 2 * (g - 1))) - (g - 1);
				cy = cy + int'($urandom_range(0, 2 * (g - 1))) - (g - 1);
			end else if (mode < 80) begin
				if ($urandom_range(0, 1) == 0)
					cx = cx + (($urandom_range(0, 1) == 0) ? g : -g);
				else
					cy = cy + (($urandom_range(0, 1) == 0) ? g : -g);
			end else if (mode < 92) begin
				cx = cx + int'($urandom_range(0, 8 * g)) - 4 * g;
				cy = cy + int'($urandom_range(0, 8 * g)) - 4 * g;
			end else begin
				cx = int'($urandom_range(0, 65535));
				cy = int'($urandom_range(0, 65535));
			end
			w  = make_point(cx, cy, rand_coord(), rand_coord(), rand_coord(),
				k == len - 1 || $urandom_range(0, 49) == 0);
			// Wrap back into the label range as the block sees it
			cx = w.cell_x;
			cy = w.cell_y;
			offer_point(w);
		end
	endtask

	// Random scans across several windows; the last phase runs without idling
	task automatic test_random_scans();
		int unsigned windows [5][4];
		int phase;
		int goal;
		int seen_from;
		windows = '{'{4, 1, 63, 4095}, '{15, 2, 40, 900}, '{1, 1, 8, 40},
			'{8, 3, 20, 200}, '{4, 2, 17, 60}};
		for (phase = 0; phase < 5; phase++) begin
			set_window(windows[phase][0], windows[phase][1], windows[phase][2],
				windows[phase][3]);
			idle_on   = (phase < 4);
			goal      = items_sent + 12;
			seen_from = clusters_seen;
			while (items_sent < goal || clusters_seen - seen_from < 3)
				random_scan();
			quiesce();
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------------

	initial begin
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;
		test_default_registers();
		test_register_extremes();
		idle_on = 1'b0;
		test_full_cluster();
		test_output_backpressure();
		test_random_scans();
		quiesce();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
